// File: rtl/i2c_master_register_access_assert.svh
// assertion macros for the i2c register access sequencer
// no dependencies; included by the rtl files that carry assertions
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2CMRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2cmra_pkg.sv
// types and constants for the i2c register access sequencer
// no dependencies
package i2cmra_pkg;

    typedef enum logic [4:0] {
        S_IDLE     = 5'd0,
        S_ST_A     = 5'd1,
        S_ST_B     = 5'd2,
        S_ST_C     = 5'd3,
        S_WB_LOW   = 5'd4,
        S_WB_DATA  = 5'd5,
        S_WB_HIGH  = 5'd6,
        S_WB_TAIL1 = 5'd7,
        S_WB_TAIL2 = 5'd8,
        S_ACK_HIGH = 5'd9,
        S_ACK_WAIT = 5'd10,
        S_ACK_LOW  = 5'd11,
        S_RB_LOW   = 5'd12,
        S_RB_REL   = 5'd13,
        S_RB_HIGH  = 5'd14,
        S_RB_FALL  = 5'd15,
        S_SP_A     = 5'd16,
        S_SP_B     = 5'd17
    } t_step;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_SHORT_DELAY = 2'd0;
    localparam logic [1:0] CFG_LONG_DELAY  = 2'd1;
    localparam logic [1:0] CFG_ACK_LIMIT   = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] LAST_BYTE_IDX = 2'd2;

    localparam logic [15:0] SHORT_DELAY_RST = 16'd1;
    localparam logic [15:0] LONG_DELAY_RST  = 16'd100;
    localparam logic [7:0]  ACK_LIMIT_RST   = 8'd250;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] device_write_byte;
        logic [7:0] register_byte;
        logic [7:0] write_data;
        logic [7:0] device_read_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_out_item;

endpackage

// File: rtl/i2c_master_register_access.sv
// i2c master register access sequencer, top level
// depends on i2cmra_pkg and i2c_master_register_access_assert.svh
//
// usage: every input word is one time tick of the bus sequencer. an idle tick
// with op write starts start / device / register / data / stop; op read starts
// start / device / register / repeated start / read address / eight bits in /
// stop. op is ignored while busy and on the finishing tick.
// every accepted input word gives exactly one output word holding the line
// levels, busy, done, the last read byte and the sticky ack_missing flag.
// latency: the output word is valid the cycle after the input word is taken.
// throughput: one word per cycle; the whole tick update is one pass of logic
// from the sequencer registers back into themselves and the output register.
// stall: while the output word waits under i_out_stall, o_in_stall is high and
// no tick is taken, so the sequencer state does not move.
// config: short/long phase lengths and the ack wait limit are written through the
// plain write port while the block is idle; the user ensures it, unchecked.
// reset (synchronous, active low): sequencer idle, both lines released high,
// registers back to 1 / 100 / 250 ticks, output register empty.
`include "i2c_master_register_access_assert.svh"

module i2c_master_register_access (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  i2cmra_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output i2cmra_pkg::t_out_item  o_out_data,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);
    import i2cmra_pkg::*;

    logic [15:0] r_short_delay;
    logic [15:0] r_long_delay;
    logic [7:0]  r_ack_limit;

    t_step       r_step,     n_step;
    logic [15:0] r_delay,    n_delay;
    logic [3:0]  r_bit_cnt,  n_bit_cnt;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [7:0]  r_shreg,    n_shreg;
    logic [7:0]  r_ack_cnt,  n_ack_cnt;
    logic [23:0] r_latched,  n_latched;
    logic        r_read_kind, n_read_kind;
    logic [7:0]  r_rx_byte,  n_rx_byte;
    logic        r_ack_flag, n_ack_flag;
    logic        r_scl,      n_scl;
    logic        r_sda,      n_sda;

    logic        r_out_valid;
    t_out_item   r_out_data, n_out_data;

    logic        in_accept;
    logic        done;
    logic        do_enter;
    t_step       tgt;
    logic        is_long;
    logic [15:0] phase_d;
    logic        sda;

    function automatic logic [7:0] sel_byte(input logic [23:0] b, input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = b[7:0];
            2'd1:    r = b[15:8];
            2'd2:    r = b[23:16];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign sda        = i_in_data.sda_in;

    // next state of the sequencer for one tick
    always_comb begin
        n_step      = r_step;
        n_delay     = r_delay;
        n_bit_cnt   = r_bit_cnt;
        n_byte_idx  = r_byte_idx;
        n_shreg     = r_shreg;
        n_ack_cnt   = r_ack_cnt;
        n_latched   = r_latched;
        n_read_kind = r_read_kind;
        n_rx_byte   = r_rx_byte;
        n_ack_flag  = r_ack_flag;
        n_scl       = r_scl;
        n_sda       = r_sda;
        done        = 1'b0;
        do_enter    = 1'b0;
        tgt         = S_IDLE;
        is_long     = 1'b0;
        phase_d     = 16'd0;

        if (r_step == S_IDLE) begin
            if (i_in_data.op == OP_WRITE || i_in_data.op == OP_READ) begin
                n_latched = {(i_in_data.op == OP_READ) ? i_in_data.device_read_byte
                                                      : i_in_data.write_data,
                             i_in_data.register_byte, i_in_data.device_write_byte};
                n_read_kind = (i_in_data.op == OP_READ);
                n_byte_idx  = 2'd0;
                n_bit_cnt   = 4'd0;
                n_ack_flag  = 1'b0;
                do_enter    = 1'b1;
                tgt         = S_ST_A;
            end
        end else if (r_step == S_ACK_WAIT && r_delay != 16'd0) begin
            if (!sda) begin
                n_delay = 16'd0;
            end else if (r_ack_cnt >= r_ack_limit) begin
                n_ack_flag = 1'b1;
                n_delay    = 16'd0;
            end else begin
                n_ack_cnt = r_ack_cnt + 8'd1;
            end
        end else if (r_delay != 16'd0) begin
            n_delay = r_delay - 16'd1;
        end else begin
            do_enter = 1'b1;
            case (r_step)
                S_ST_A:     tgt = S_ST_B;
                S_ST_B:     tgt = S_ST_C;
                S_ST_C: begin
                    n_shreg   = sel_byte(r_latched, r_byte_idx);
                    n_bit_cnt = 4'd0;
                    tgt       = S_WB_LOW;
                end
                S_WB_LOW:   tgt = S_WB_DATA;
                S_WB_DATA:  tgt = S_WB_HIGH;
                S_WB_HIGH: begin
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    tgt = (n_bit_cnt < BITS_PER_BYTE) ? S_WB_LOW : S_WB_TAIL1;
                end
                S_WB_TAIL1: tgt = S_WB_TAIL2;
                S_WB_TAIL2: tgt = S_ACK_HIGH;
                S_ACK_HIGH: tgt = S_ACK_WAIT;
                S_ACK_WAIT: tgt = S_ACK_LOW;
                S_ACK_LOW: begin
                    if (r_byte_idx >= LAST_BYTE_IDX) begin
                        if (r_read_kind) begin
                            n_shreg   = 8'd0;
                            n_bit_cnt = 4'd0;
                            tgt       = S_RB_LOW;
                        end else begin
                            tgt = S_SP_A;
                        end
                    end else begin
                        n_byte_idx = r_byte_idx + 2'd1;
                        // read turns around with a repeated start before the last byte
                        if (n_byte_idx == LAST_BYTE_IDX && r_read_kind) begin
                            tgt = S_ST_A;
                        end else begin
                            n_shreg   = sel_byte(r_latched, n_byte_idx);
                            n_bit_cnt = 4'd0;
                            tgt       = S_WB_LOW;
                        end
                    end
                end
                S_RB_LOW:   tgt = S_RB_REL;
                S_RB_REL:   tgt = S_RB_HIGH;
                S_RB_HIGH: begin
                    n_shreg   = {r_shreg[6:0], sda};
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    tgt       = S_RB_FALL;
                end
                S_RB_FALL: begin
                    if (r_bit_cnt >= BITS_PER_BYTE) begin
                        n_rx_byte = r_shreg;
                        tgt       = S_SP_A;
                    end else begin
                        tgt = S_RB_HIGH;
                    end
                end
                S_SP_A:     tgt = S_SP_B;
                S_SP_B: begin
                    do_enter = 1'b0;
                    n_step   = S_IDLE;
                    n_delay  = 16'd0;
                    done     = 1'b1;
                end
                default: begin
                    do_enter = 1'b0;
                    n_step   = S_IDLE;
                    n_delay  = 16'd0;
                end
            endcase
        end

        // entry effects of the new phase
        if (do_enter) begin
            n_step = tgt;
            case (tgt)
                S_ST_A:     begin n_scl = 1'b1; n_sda = 1'b1; end
                S_ST_B:     begin n_scl = 1'b1; n_sda = 1'b0; end
                S_ST_C:     begin n_scl = 1'b0; n_sda = 1'b0; end
                S_WB_LOW:   n_scl = 1'b0;
                S_WB_DATA: begin
                    n_sda   = n_shreg[7];
                    n_shreg = {n_shreg[6:0], 1'b0};
                end
                S_WB_HIGH:  n_scl = 1'b1;
                S_WB_TAIL1: begin n_scl = 1'b0; is_long = 1'b1; end
                S_WB_TAIL2: begin n_sda = 1'b1; is_long = 1'b1; end
                S_ACK_HIGH: n_scl = 1'b1;
                S_ACK_LOW:  n_scl = 1'b0;
                S_RB_LOW:   begin n_scl = 1'b0; is_long = 1'b1; end
                S_RB_REL:   begin n_sda = 1'b1; is_long = 1'b1; end
                S_RB_HIGH:  begin n_scl = 1'b1; is_long = 1'b1; end
                S_RB_FALL:  begin n_scl = 1'b0; is_long = 1'b1; end
                S_SP_A:     begin n_scl = 1'b1; n_sda = 1'b0; end
                S_SP_B:     n_sda = 1'b1;
                default:    ;
            endcase
            phase_d = is_long ? r_long_delay : r_short_delay;
            // a zero delay register acts as one tick
            n_delay = (phase_d == 16'd0) ? 16'd0 : phase_d - 16'd1;
            if (tgt == S_ACK_WAIT) begin
                // wait counter cleared on entry, sda checked on the entry tick too
                n_scl     = 1'b1;
                n_ack_cnt = 8'd0;
                n_delay   = 16'd1;
                if (!sda) begin
                    n_delay = 16'd0;
                end else if (r_ack_limit == 8'd0) begin
                    n_ack_flag = 1'b1;
                    n_delay    = 16'd0;
                end else begin
                    n_ack_cnt = 8'd1;
                end
            end
        end
    end

    // result word for this tick
    always_comb begin
        n_out_data.scl_out     = n_scl;
        n_out_data.sda_out     = n_sda;
        n_out_data.busy_res    = (n_step != S_IDLE);
        n_out_data.done_res    = done;
        n_out_data.read_data   = n_rx_byte;
        n_out_data.ack_missing = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_delay <= SHORT_DELAY_RST;
            r_long_delay  <= LONG_DELAY_RST;
            r_ack_limit   <= ACK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHORT_DELAY: r_short_delay <= i_cfg_data;
                CFG_LONG_DELAY:  r_long_delay  <= i_cfg_data;
                CFG_ACK_LIMIT:   r_ack_limit   <= i_cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_delay     <= 16'd0;
            r_bit_cnt   <= 4'd0;
            r_byte_idx  <= 2'd0;
            r_shreg     <= 8'd0;
            r_ack_cnt   <= 8'd0;
            r_latched   <= 24'd0;
            r_read_kind <= 1'b0;
            r_rx_byte   <= 8'd0;
            r_ack_flag  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (in_accept) begin
            r_step      <= n_step;
            r_delay     <= n_delay;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_idx  <= n_byte_idx;
            r_shreg     <= n_shreg;
            r_ack_cnt   <= n_ack_cnt;
            r_latched   <= n_latched;
            r_read_kind <= n_read_kind;
            r_rx_byte   <= n_rx_byte;
            r_ack_flag  <= n_ack_flag;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `I2CMRA_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n,
        o_out_valid && o_out_data.done_res, !o_out_data.busy_res,
        "done reported while still busy")
    `I2CMRA_ASSERT_NOW(a_ack_scl_high, i_clk, i_rst_n,
        r_step == S_ACK_WAIT, r_scl, "scl low during acknowledge wait")
    `I2CMRA_ASSERT_NEXT(a_start_write, i_clk, i_rst_n,
        in_accept && r_step == S_IDLE && i_in_data.op == OP_WRITE,
        r_step == S_ST_A && !r_read_kind, "write op did not start a transaction")
    `I2CMRA_ASSERT_NEXT(a_stalled_held, i_clk, i_rst_n,
        r_out_valid && i_out_stall, r_out_valid && $stable(r_step),
        "stalled word dropped or sequencer moved")
    `I2CMRA_ASSERT_NOW(a_bit_cnt_range, i_clk, i_rst_n,
        1'b1, r_bit_cnt <= BITS_PER_BYTE, "bit counter past one byte")

endmodule
